/* hw/rtl/msat_pkg.sv */
package msat_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TIME_W = 23;
  localparam int TYPE_W = 8;

  // input tdata layout, lowest bit first
  localparam int EL_LSB     = 0;
  localparam int TYPE_LSB   = EL_LSB + TIME_W;
  localparam int PER_LSB    = TYPE_LSB + TYPE_W;
  localparam int DLY_LSB    = PER_LSB + 1;
  localparam int IN_FIELD_W = DLY_LSB + TIME_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TYPE_W + 7) / 8) * 8;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PROG = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the request, restart the scan
    logic prog_scan;   // compare one slot for a program request
    logic prog_apply;  // write the matched or free slot
    logic tick_step;   // age or fire one slot
    logic flush;       // hand out the held event as the last one
  } msat_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;    // scan index sits on the last slot
    logic step_ok;     // tick step may complete this cycle
    logic flush_ok;    // held event gone or leaving now
  } msat_sts_t;

endpackage

/* hw/rtl/msat_ctrl.sv */
module msat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_kind,
  output logic                in_tready,
  output msat_pkg::msat_cmd_t cmd,
  input  msat_pkg::msat_sts_t sts
);
  import msat_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PSCAN  = 5'b00010,
    ST_PAPPLY = 5'b00100,
    ST_TSCAN  = 5'b01000,
    ST_TFLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_PROG) ? ST_PSCAN : ST_TSCAN;
        end
      end
      ST_PSCAN: begin
        cmd.prog_scan = 1'b1;
        if (sts.idx_last) state_nxt = ST_PAPPLY;
      end
      ST_PAPPLY: begin
        cmd.prog_apply = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_TSCAN: begin
        cmd.tick_step = 1'b1;
        if (sts.step_ok && sts.idx_last) state_nxt = ST_TFLUSH;
      end
      ST_TFLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hw/rtl/msat_dp.sv */
module msat_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msat_pkg::msat_cmd_t                 cmd,
  output msat_pkg::msat_sts_t                 sts,
  input  logic [msat_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [msat_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import msat_pkg::*;

  // slot table
  logic              used_r   [SLOTS];
  logic [TYPE_W-1:0] type_r   [SLOTS];
  logic              per_r    [SLOTS];
  logic [TIME_W-1:0] period_r [SLOTS];
  logic [TIME_W-1:0] rem_r    [SLOTS];

  // captured request
  logic [TIME_W-1:0] el_r, dly_r;
  logic [TYPE_W-1:0] typ_r;
  logic              prd_r;

  logic [IDX_W-1:0]  idx_r;
  logic              match_v_r, free_v_r;
  logic [IDX_W-1:0]  match_idx_r, free_idx_r;

  // event held back until we know whether it is the last one
  logic              pend_v_r;
  logic [TYPE_W-1:0] pend_type_r;

  logic              out_v_r, out_last_r;
  logic [TYPE_W-1:0] out_type_r;

  logic              cur_used, expire, out_free, tick_en, push_step, push_flush;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_used_en, wr_used_val, wr_rem_en, wr_all_en;
  logic [TIME_W-1:0] wr_rem_val;

  always_comb begin
    cur_used   = used_r[idx_r];
    expire     = cur_used && (rem_r[idx_r] <= el_r);
    out_free   = !out_v_r || out_tready;
    sts.idx_last = (idx_r == IDX_W'(SLOTS - 1));
    sts.step_ok  = !(expire && pend_v_r && !out_free);
    sts.flush_ok = !pend_v_r || out_free;
    tick_en    = cmd.tick_step && sts.step_ok;
    push_step  = tick_en && expire && pend_v_r;
    push_flush = cmd.flush && pend_v_r && out_free;
  end

  // single write port into the table
  always_comb begin
    wr_idx      = idx_r;
    wr_used_en  = 1'b0;
    wr_used_val = 1'b0;
    wr_rem_en   = 1'b0;
    wr_rem_val  = rem_r[idx_r] - el_r;
    wr_all_en   = 1'b0;
    if (cmd.prog_apply) begin
      wr_rem_val = dly_r;
      if (match_v_r) begin
        wr_idx = match_idx_r;
        if (dly_r == '0) wr_used_en = 1'b1;
        else             wr_rem_en  = 1'b1;
      end else if (free_v_r) begin
        wr_idx      = free_idx_r;
        wr_used_en  = 1'b1;
        wr_used_val = 1'b1;
        wr_all_en   = 1'b1;
      end
    end else if (tick_en && cur_used) begin
      if (!expire) begin
        wr_rem_en = 1'b1;
      end else if (per_r[idx_r]) begin
        wr_rem_en  = 1'b1;
        wr_rem_val = period_r[idx_r];
      end else begin
        wr_used_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) used_r[i] <= 1'b0;
    end else if (wr_used_en) begin
      used_r[wr_idx] <= wr_used_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_rem_en || wr_all_en) rem_r[wr_idx] <= wr_rem_val;
    if (wr_all_en) begin
      type_r[wr_idx]   <= typ_r;
      per_r[wr_idx]    <= prd_r;
      period_r[wr_idx] <= dly_r;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      el_r  <= in_tdata[EL_LSB +: TIME_W];
      typ_r <= in_tdata[TYPE_LSB +: TYPE_W];
      prd_r <= in_tdata[PER_LSB];
      dly_r <= in_tdata[DLY_LSB +: TIME_W];
    end
    if (cmd.prog_scan) begin
      if (cur_used && type_r[idx_r] == typ_r && !match_v_r) match_idx_r <= idx_r;
      if (!cur_used && !free_v_r) free_idx_r <= idx_r;
    end
    if (tick_en && expire) pend_type_r <= type_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      match_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        match_v_r <= 1'b0;
        free_v_r  <= 1'b0;
        pend_v_r  <= 1'b0;
      end else begin
        if (cmd.prog_scan || tick_en) idx_r <= idx_r + 1'b1;
        if (cmd.prog_scan && cur_used && type_r[idx_r] == typ_r) match_v_r <= 1'b1;
        if (cmd.prog_scan && !cur_used) free_v_r <= 1'b1;
        if (tick_en && expire)          pend_v_r <= 1'b1;
        else if (push_flush)            pend_v_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (push_step || push_flush) begin
      out_type_r <= pend_type_r;
      out_last_r <= push_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                       out_v_r <= 1'b0;
    else if (push_step || push_flush) out_v_r <= 1'b1;
    else if (out_tready)              out_v_r <= 1'b0;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_type_r);
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/multi_slot_alarm_timer.sv */
// Eight-slot alarm timer.
// Input stream: one request per handshake. in_tuser is the kind: 0 = tick,
// 1 = program/cancel. A tick ages every busy slot by elapsed_time; a program
// request creates, reloads or (delay 0) cancels the alarm of its type.
// Output stream: one event per fired alarm, event type in out_tdata,
// out_tlast on the last event of a tick. A tick with no expiry gives nothing.
// Timing: the slot table is scanned one slot per cycle through a single
// compare/subtract unit, unless a tick scan is held by a stall. A program
// request is scanned, then applied, before in_tready rises again. A tick
// is scanned and then flushed, and lasts longer while the receiver stalls;
// events come out in slot order, each one after its slot is scanned, since
// it is held until the next expiry or the end of the scan decides its tlast.
// Stalls: a full output register holds the scan on the next expiry; the
// next request is taken while the last event still waits in the register.
// Reset (rst_n low, synchronous) frees all slots and empties the output.
module multi_slot_alarm_timer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // elapsed_time[22:0], alarm_type[30:23], periodic[31], delay[54:32], pad
  input  logic [msat_pkg::IN_DATA_W-1:0]       in_tdata,
  // kind
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // event_type[7:0]
  output logic [msat_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import msat_pkg::*;

  msat_cmd_t cmd;
  msat_sts_t sts;

  // sequencer: accept, scan, apply or flush
  msat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // slot table, compare/subtract unit, output register
  msat_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
